/* sv/mlfqc_pkg.sv */
// Package for the scheduler fixed-point calculation unit.
// Holds the 17.14 format constants, operation codes and the request/response
// structs shared by the top level and its serial multiply and divide units.
package mlfqc_pkg;

	localparam int FRAC_BITS   = 14;
	localparam int F_ONE       = 1 << FRAC_BITS;
	localparam int HALF_ONE    = F_ONE / 2;
	localparam int MAX_THREADS = 64;
	localparam int PRI_TOP     = 63;

	// Load average is held as a non-negative value up to (MAX_THREADS+1) in 17.14.
	localparam int LOAD_CAP = (MAX_THREADS + 1) * F_ONE;
	localparam int LOAD_W   = $clog2(LOAD_CAP + 1);
	localparam int LOAD_X100_MAX = (MAX_THREADS + 1) * 100;

	localparam int C59 = (59 * F_ONE) / 60;
	localparam int C1  = F_ONE / 60;
	localparam int PCT = 100;

	// Serial multiplier: 32-bit magnitude times a multiplier of up to FRAC_BITS bits.
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = FRAC_BITS;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int PCT_STEPS = 7;

	// Divider: remainder and divisor never exceed 2*LOAD_CAP + F_ONE.
	localparam int DIV_W = LOAD_W + 1;

	// Width of the rounded magnitude of recent cpu times 100.
	localparam int RX_W = 24;

	localparam logic [1:0] FUNC_LOAD_AVG = 2'd0;
	localparam logic [1:0] FUNC_DECAY    = 2'd1;
	localparam logic [1:0] FUNC_PRIORITY = 2'd2;
	localparam logic [1:0] FUNC_TICK     = 2'd3;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic               start;
		logic               short_op;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [FRAC_BITS-1:0] quot;
	} div_rsp_t;

endpackage

/* sv/mlfqc_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on mlfqc_pkg for widths and the request/response structs.
module mlfqc_serial_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  mlfqc_pkg::mul_req_t req,
	output mlfqc_pkg::mul_rsp_t rsp
);
	import mlfqc_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_A_W-1:0] hi_q;
	logic [MUL_B_W-1:0] lo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               short_q;
	logic [MUL_A_W:0]   sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(MUL_A_W + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.short_op ? CNT_W'(PCT_STEPS) : CNT_W'(MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q     <= req.a;
			hi_q    <= '0;
			lo_q    <= req.b;
			short_q <= req.short_op;
		end else if (busy_q) begin
			hi_q <= sum[MUL_A_W:1];
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	// A short run leaves the product aligned PCT_STEPS places too far left in lo.
	assign rsp.done = done_q;
	assign rsp.prod = short_q ?
		{{(MUL_B_W - PCT_STEPS){1'b0}}, hi_q, lo_q[MUL_B_W-1 -: PCT_STEPS]} :
		{hi_q, lo_q};

endmodule

/* sv/mlfqc_serial_div.sv */
// Restoring divider producing one quotient bit per cycle.
// Depends on mlfqc_pkg; the dividend is num followed by FRAC_BITS zero bits, num < den.
module mlfqc_serial_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mlfqc_pkg::div_req_t req,
	output mlfqc_pkg::div_rsp_t rsp
);
	import mlfqc_pkg::*;

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W+1:0]     diff;

	assign shifted = {rem_q, 1'b0};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (!diff[DIV_W+1]) begin
				rem_q  <= diff[DIV_W-1:0];
				quot_q <= {quot_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[DIV_W-1:0];
				quot_q <= {quot_q[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* sv/mlfq_scheduler_fixed_point_calc_unit.sv */
// Top level of the scheduler fixed-point calculation unit (17.14 format).
// Depends on mlfqc_pkg, mlfqc_serial_mul and mlfqc_serial_div.
//
// Usage: one input transaction (func, recent_cpu_in, nice_in, is_idle,
// ready_count) on in_valid/in_ready produces exactly one output transaction
// on out_valid/out_ready. The unit holds the system load average internally.
// Items are processed one at a time; in_ready is high only while the
// sequencer is idle. The result sits in an output register, so a new item
// is taken while an earlier result still waits for out_ready.
// Steps after acceptance, with the serial multiplier working one bit a cycle
// and the serial divider one quotient bit a cycle:
//   priority, tick and idle-thread decay items: setup, then recent cpu times 100;
//   load average update: setup, load times 59/60, load times 100, recent cpu times 100;
//   recent cpu decay: setup, divide, recent cpu times coefficient, recent cpu times 100.
// Reset clears the load average and its times-100 figure to zero and empties
// the output register. If the receiver stalls, the finished result waits in
// the sequencer until the output register is free; no result is dropped.
module mlfq_scheduler_fixed_point_calc_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] recent_cpu_in,
	input  logic signed [5:0]  nice_in,
	input  logic               is_idle,
	input  logic [6:0]         ready_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] recent_cpu_out,
	output logic [5:0]         priority_out,
	output logic [12:0]        load_avg_x100,
	output logic signed [31:0] recent_cpu_x100
);
	import mlfqc_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SETUP = 9'b000000010,
		ST_DIV   = 9'b000000100,
		ST_MRC   = 9'b000001000,
		ST_MLOAD = 9'b000010000,
		ST_MLX   = 9'b000100000,
		ST_RGO   = 9'b001000000,
		ST_MRX   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [1:0]         func_q;
	logic [31:0]        rc_q;
	logic [31:0]        rc_mag_q;
	logic [5:0]         nice_q;
	logic               idle_q;
	logic [16:0]        c1r_q;
	logic [LOAD_W-1:0]  load_q;
	logic [12:0]        load_x100_q;
	logic [31:0]        rc_out_q;
	logic [5:0]         prio_q;
	logic [RX_W-1:0]    rnd_q;
	logic               out_valid_q;
	logic [31:0]        out_rc_q;
	logic [5:0]         out_prio_q;
	logic [12:0]        out_load_q;
	logic [31:0]        out_rcx_q;

	logic               accept;
	logic [7:0]         ready_eff;
	logic [16:0]        c1r_d;
	logic [31:0]        rc_mag_d;
	logic [7:0]         kint;
	logic [32:0]        kfix;
	logic [32:0]        pv;
	logic [5:0]         prio_calc;
	logic [32:0]        tick_sum;
	logic [31:0]        tick_out;
	logic [31:0]        decay_mag;
	logic [33:0]        nice_fix;
	logic [33:0]        decay_sum;
	logic [31:0]        decay_out;
	logic [LOAD_W:0]    load_sum;
	logic [LOAD_W-1:0]  load_d;
	logic [PROD_W-1:0]  rounded;
	logic [31:0]        rc_out_mag;
	logic [31:0]        rcx_out;
	logic               out_free;

	mlfqc_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mlfqc_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Values prepared while the transaction is taken.
	assign ready_eff = {1'b0, ready_count} + {7'b0, !is_idle};
	assign c1r_d     = {9'b0, ready_eff} * 17'(C1);
	assign rc_mag_d  = recent_cpu_in[31] ? (~recent_cpu_in + 32'd1) : recent_cpu_in;

	// Priority: rc/-4 truncates toward zero, so it is minus sign times |rc|/4.
	assign kint = 8'(PRI_TOP) - {nice_q[5], nice_q, 1'b0};
	assign kfix = {{(33 - 8 - FRAC_BITS){1'b0}}, kint, {FRAC_BITS{1'b0}}};
	assign pv   = rc_q[31] ? kfix + {3'b0, rc_mag_q[31:2]} : kfix - {3'b0, rc_mag_q[31:2]};

	always_comb begin
		if (pv[32]) begin
			prio_calc = '0;
		end else if (pv[31:FRAC_BITS] > (32 - FRAC_BITS)'(PRI_TOP)) begin
			prio_calc = 6'(PRI_TOP);
		end else begin
			prio_calc = pv[FRAC_BITS+5:FRAC_BITS];
		end
	end

	assign tick_sum = {rc_q[31], rc_q} + 33'(F_ONE);
	assign tick_out = (!tick_sum[32] && tick_sum[31]) ? S32_MAX : tick_sum[31:0];

	// Decay: product magnitude is truncated, then the sign of rc is restored.
	assign decay_mag = mul_rsp.prod[FRAC_BITS+31:FRAC_BITS];
	assign nice_fix  = {{(34 - 6 - FRAC_BITS){nice_q[5]}}, nice_q, {FRAC_BITS{1'b0}}};
	assign decay_sum = rc_q[31] ? nice_fix - {2'b0, decay_mag} : nice_fix + {2'b0, decay_mag};

	always_comb begin
		if (decay_sum[33:31] == 3'b000 || decay_sum[33:31] == 3'b111) begin
			decay_out = decay_sum[31:0];
		end else if (decay_sum[33]) begin
			decay_out = S32_MIN;
		end else begin
			decay_out = S32_MAX;
		end
	end

	// The load average is never negative, so its product truncates by a shift.
	assign load_sum = {1'b0, mul_rsp.prod[FRAC_BITS+LOAD_W-1:FRAC_BITS]}
		+ (LOAD_W + 1)'(c1r_q);
	assign load_d   = (load_sum > (LOAD_W + 1)'(LOAD_CAP)) ? LOAD_W'(LOAD_CAP)
		: load_sum[LOAD_W-1:0];

	assign rounded    = mul_rsp.prod + PROD_W'(HALF_ONE);
	assign rc_out_mag = rc_out_q[31] ? (~rc_out_q + 32'd1) : rc_out_q;
	assign rcx_out    = rc_out_q[31] ? (~{{(32 - RX_W){1'b0}}, rnd_q} + 32'd1)
		: {{(32 - RX_W){1'b0}}, rnd_q};

	always_comb begin
		state_d = state_q;
		mul_req = '0;
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				case (func_q)
					FUNC_LOAD_AVG: begin
						mul_req.start = 1'b1;
						mul_req.a     = MUL_A_W'(load_q);
						mul_req.b     = MUL_B_W'(C59);
						state_d       = ST_MLOAD;
					end
					FUNC_DECAY: begin
						if (idle_q) begin
							state_d = ST_RGO;
						end else begin
							div_req.start = 1'b1;
							div_req.num   = {load_q, 1'b0};
							div_req.den   = {load_q, 1'b0} + DIV_W'(F_ONE);
							state_d       = ST_DIV;
						end
					end
					default: begin
						state_d = ST_RGO;
					end
				endcase
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = rc_mag_q;
					mul_req.b     = div_rsp.quot;
					state_d       = ST_MRC;
				end
			end
			ST_MRC: begin
				if (mul_rsp.done) begin
					state_d = ST_RGO;
				end
			end
			ST_MLOAD: begin
				if (mul_rsp.done) begin
					mul_req.start    = 1'b1;
					mul_req.short_op = 1'b1;
					mul_req.a        = MUL_A_W'(load_d);
					mul_req.b        = MUL_B_W'(PCT);
					state_d          = ST_MLX;
				end
			end
			ST_MLX: begin
				if (mul_rsp.done) begin
					state_d = ST_RGO;
				end
			end
			ST_RGO: begin
				mul_req.start    = 1'b1;
				mul_req.short_op = 1'b1;
				mul_req.a        = rc_out_mag;
				mul_req.b        = MUL_B_W'(PCT);
				state_d          = ST_MRX;
			end
			ST_MRX: begin
				if (mul_rsp.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			load_q      <= '0;
			load_x100_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MLOAD && mul_rsp.done) begin
				load_q <= load_d;
			end
			if (state_q == ST_MLX && mul_rsp.done) begin
				load_x100_q <= rounded[FRAC_BITS+12:FRAC_BITS];
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			rc_q     <= recent_cpu_in;
			rc_mag_q <= rc_mag_d;
			nice_q   <= nice_in;
			idle_q   <= is_idle;
			c1r_q    <= c1r_d;
		end
		if (state_q == ST_SETUP) begin
			if (!idle_q && func_q == FUNC_PRIORITY) begin
				prio_q <= prio_calc;
			end else begin
				prio_q <= '0;
			end
			if (!idle_q && func_q == FUNC_TICK) begin
				rc_out_q <= tick_out;
			end else begin
				rc_out_q <= rc_q;
			end
		end
		if (state_q == ST_MRC && mul_rsp.done) begin
			rc_out_q <= decay_out;
		end
		if (state_q == ST_MRX && mul_rsp.done) begin
			rnd_q <= rounded[FRAC_BITS+RX_W-1:FRAC_BITS];
		end
		if (state_q == ST_FIN && out_free) begin
			out_rc_q   <= rc_out_q;
			out_prio_q <= prio_q;
			out_load_q <= load_x100_q;
			out_rcx_q  <= rcx_out;
		end
	end

	assign out_valid       = out_valid_q;
	assign recent_cpu_out  = out_rc_q;
	assign priority_out    = out_prio_q;
	assign load_avg_x100   = out_load_q;
	assign recent_cpu_x100 = out_rcx_q;

endmodule

/* sv/mlfqc_checker.sv */
// Port-level checker for the scheduler fixed-point calculation unit.
// Depends on mlfqc_pkg; bound to the top level at the end of this file.
module mlfqc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] recent_cpu_out,
	input logic [5:0]         priority_out,
	input logic [12:0]        load_avg_x100,
	input logic signed [31:0] recent_cpu_x100
);
	import mlfqc_pkg::*;

	// A stalled result must be held until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(recent_cpu_out)
			&& $stable(recent_cpu_x100))
		else $error("stalled result changed");

	// Items are worked on one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	a_prio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> priority_out <= 6'(PRI_TOP))
		else $error("priority above the top level");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> load_avg_x100 <= 13'(LOAD_X100_MAX))
		else $error("load average beyond its cap");

	// Scaling by 100 with symmetric rounding cannot turn a non-negative value negative.
	a_x100_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !recent_cpu_out[31] |-> !recent_cpu_x100[31])
		else $error("recent cpu times 100 has the wrong sign");

endmodule

bind mlfq_scheduler_fixed_point_calc_unit mlfqc_checker u_mlfqc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.recent_cpu_out  (recent_cpu_out),
	.priority_out    (priority_out),
	.load_avg_x100   (load_avg_x100),
	.recent_cpu_x100 (recent_cpu_x100)
);

/* tb/tb_top.sv */
// Self-checking testbench for mlfq_scheduler_fixed_point_calc_unit.
// Drives random and directed transactions through valid/ready and checks each result
// against a predictor in the bench. Depends only on mlfqc_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mlfqc_pkg::*;

	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam int     MAX_PRINTS = 40;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] rc;
		logic [5:0]  nice;
		logic        idle;
		logic [6:0]  ready;
		logic        drain;
	} sched_req_t;

	typedef struct packed {
		logic [31:0] rc_out;
		logic [5:0]  prio;
		logic [12:0] load_x100;
		logic [31:0] rc_x100;
	} sched_res_t;

	typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_STALL} rx_mode_e;
	typedef enum {TREND_UP, TREND_DOWN, TREND_MIXED} load_trend_e;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         func = FUNC_LOAD_AVG;
	logic signed [31:0] recent_cpu_in = '0;
	logic signed [5:0]  nice_in = '0;
	logic               is_idle = 1'b0;
	logic [6:0]         ready_count = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] recent_cpu_out;
	logic [5:0]         priority_out;
	logic [12:0]        load_avg_x100;
	logic signed [31:0] recent_cpu_x100;

	sched_req_t req_queue[$];
	sched_res_t due_results[$];
	longint     model_load = 0;
	int         mismatches = 0;
	int         n_results = 0;
	int         busy_cnt = 0;
	int         gap_left = 0;
	int         burst_left = 1;
	rx_mode_e   rx_mode = RX_STREAM;
	int         rx_left = 0;

	mlfq_scheduler_fixed_point_calc_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.recent_cpu_in  (recent_cpu_in),
		.nice_in        (nice_in),
		.is_idle        (is_idle),
		.ready_count    (ready_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.recent_cpu_out (recent_cpu_out),
		.priority_out   (priority_out),
		.load_avg_x100  (load_avg_x100),
		.recent_cpu_x100(recent_cpu_x100)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clip_s32(longint v);
		if (v > S32_HI) return S32_HI;
		if (v < S32_LO) return S32_LO;
		return v;
	endfunction

	// Halves are rounded away from zero; division truncates towards zero.
	function automatic longint round_fixed(longint x);
		if (x >= 0) return (x + HALF_ONE) / F_ONE;
		return (x - HALF_ONE) / F_ONE;
	endfunction

	// Works out the result of one transaction and advances the load average.
	function automatic sched_res_t sched_predict(logic [1:0] f, logic signed [31:0] rc_in,
			logic signed [5:0] nice_v, logic idle, logic [6:0] ready_v);
		sched_res_t r;
		longint     rc;
		longint     nice;
		longint     rdy;
		longint     rc_res;
		longint     prio;
		longint     nl;
		longint     two_l;
		longint     coef;
		longint     v;
		rc = rc_in;
		nice = nice_v;
		rdy = ready_v;
		rc_res = rc;
		prio = 0;
		case (f)
			FUNC_LOAD_AVG: begin
				if (!idle) rdy = rdy + 1;
				nl = (C59 * model_load) / F_ONE + C1 * rdy;
				if (nl < 0) nl = 0;
				if (nl > LOAD_CAP) nl = LOAD_CAP;
				model_load = nl;
			end
			FUNC_DECAY: begin
				if (!idle) begin
					two_l = 2 * model_load;
					coef = (two_l * F_ONE) / (two_l + F_ONE);
					rc_res = clip_s32((coef * rc) / F_ONE + nice * F_ONE);
				end
			end
			FUNC_PRIORITY: begin
				if (!idle) begin
					v = rc / -64'sd4 + (PRI_TOP - 2 * nice) * F_ONE;
					v = v / F_ONE;
					if (v < 0) v = 0;
					if (v > PRI_TOP) v = PRI_TOP;
					prio = v;
				end
			end
			default: begin
				if (!idle) rc_res = clip_s32(rc + F_ONE);
			end
		endcase
		v = round_fixed(model_load * PCT);
		r.load_x100 = v[12:0];
		r.rc_out = rc_res[31:0];
		r.prio = prio[5:0];
		v = clip_s32(round_fixed(rc_res * PCT));
		r.rc_x100 = v[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		// Printing is capped so that a broken design cannot flood the log.
		if (mismatches < MAX_PRINTS) $display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task automatic add_item(logic [1:0] f, int rc, int nv, logic idl, int rdy, logic drn);
		sched_req_t it;
		it.func = f;
		it.rc = rc;
		it.nice = nv[5:0];
		it.idle = idl;
		it.ready = rdy[6:0];
		it.drain = drn;
		req_queue.push_back(it);
	endtask

	function automatic int pick_recent_cpu();
		case ($urandom_range(0, 5))
			0: return int'($urandom);
			1: return int'($urandom_range(0, 128 * F_ONE)) - 64 * F_ONE;
			2: return int'(S32_HI) - int'($urandom_range(0, 2 * F_ONE));
			3: return int'(S32_LO) + int'($urandom_range(0, 2 * F_ONE));
			4: return int'($urandom_range(0, 100 * F_ONE));
			default: return int'($urandom_range(0, 64)) - 32;
		endcase
	endfunction

	task automatic add_random_item(load_trend_e trend, logic drn);
		logic [1:0] f;
		int         nv;
		int         rdy;
		logic       idl;
		idl = ($urandom_range(0, 7) == 0);
		rdy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 64);
		if (($urandom_range(0, 6) == 0)) nv = $urandom_range(0, 63);
		else nv = int'($urandom_range(0, 40)) - 20;
		case ($urandom_range(0, 2))
			0: f = FUNC_DECAY;
			1: f = FUNC_PRIORITY;
			default: f = FUNC_TICK;
		endcase
		case (trend)
			TREND_UP: begin
				if ($urandom_range(0, 9) < 7) begin
					f = FUNC_LOAD_AVG;
					rdy = $urandom_range(64, 127);
					idl = ($urandom_range(0, 9) == 0);
				end
			end
			TREND_DOWN: begin
				if ($urandom_range(0, 1) == 0) begin
					f = FUNC_LOAD_AVG;
					rdy = $urandom_range(0, 3);
					idl = ($urandom_range(0, 1) == 1);
				end
			end
			default: begin
				if ($urandom_range(0, 3) == 0) f = FUNC_LOAD_AVG;
			end
		endcase
		add_item(f, pick_recent_cpu(), nv, idl, rdy, drn);
	endtask

	// Sender: bursts of transactions separated by random gaps.
	always @(posedge clk) begin : drive_proc
		logic       took;
		int         next_busy;
		sched_req_t nxt;
		if (arst_n) begin
			next_busy = busy_cnt + (in_valid && in_ready) - (out_valid && out_ready);
			busy_cnt = next_busy;
			if (!in_valid || in_ready) begin
				took = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (req_queue.size() != 0 && !(req_queue[0].drain && next_busy != 0))
					took = 1'b1;
				if (took) begin
					nxt = req_queue.pop_front();
					func <= nxt.func;
					recent_cpu_in <= nxt.rc;
					nice_in <= nxt.nice;
					is_idle <= nxt.idle;
					ready_count <= nxt.ready;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: each stall pattern holds for a random stretch of cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 300);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_STREAM: out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= (rx_left % 64 == 0);
			endcase
		end
	end

	always @(posedge clk) begin : check_proc
		sched_res_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				due_results.push_back(sched_predict(func, recent_cpu_in, nice_in, is_idle,
					ready_count));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none due", n_results));
				end else begin
					want = due_results.pop_front();
					if (recent_cpu_out !== want.rc_out)
						report_mismatch($sformatf("result %0d recent_cpu_out %0d, want %0d",
							n_results, recent_cpu_out, $signed(want.rc_out)));
					if (priority_out !== want.prio)
						report_mismatch($sformatf("result %0d priority_out %0d, want %0d",
							n_results, priority_out, want.prio));
					if (load_avg_x100 !== want.load_x100)
						report_mismatch($sformatf("result %0d load_avg_x100 %0d, want %0d",
							n_results, load_avg_x100, want.load_x100));
					if (recent_cpu_x100 !== want.rc_x100)
						report_mismatch($sformatf("result %0d recent_cpu_x100 %0d, want %0d",
							n_results, recent_cpu_x100, $signed(want.rc_x100)));
				end
				n_results++;
			end
		end
	end

	initial begin : stimulus_proc
		load_trend_e trend;
		int          seg_len;
		int          n_rand;
		// Directed part: field extremes, idle thread and the saturating cases.
		add_item(FUNC_PRIORITY, 0, 0, 1'b0, 0, 1'b0);
		add_item(FUNC_PRIORITY, int'(S32_LO), -20, 1'b0, 0, 1'b0);
		add_item(FUNC_PRIORITY, int'(S32_HI), 20, 1'b0, 0, 1'b0);
		add_item(FUNC_PRIORITY, -3, -32, 1'b0, 0, 1'b0);
		add_item(FUNC_PRIORITY, 5 * F_ONE, 31, 1'b1, 0, 1'b0);
		add_item(FUNC_TICK, int'(S32_HI), 0, 1'b0, 0, 1'b0);
		add_item(FUNC_TICK, int'(S32_LO), 0, 1'b0, 0, 1'b0);
		add_item(FUNC_TICK, -F_ONE, 0, 1'b0, 0, 1'b0);
		add_item(FUNC_TICK, int'(S32_HI), 0, 1'b1, 0, 1'b0);
		add_item(FUNC_DECAY, 123457, -20, 1'b0, 0, 1'b0);
		add_item(FUNC_LOAD_AVG, -1, 0, 1'b0, 127, 1'b0);
		add_item(FUNC_LOAD_AVG, 0, 0, 1'b1, 0, 1'b0);
		add_item(FUNC_LOAD_AVG, 0, 0, 1'b1, 127, 1'b0);
		add_item(FUNC_LOAD_AVG, 0, 0, 1'b0, 64, 1'b0);
		add_item(FUNC_DECAY, int'(S32_HI), 31, 1'b0, 0, 1'b0);
		add_item(FUNC_DECAY, int'(S32_LO), -32, 1'b0, 0, 1'b0);
		add_item(FUNC_DECAY, -98765, 7, 1'b0, 0, 1'b0);
		add_item(FUNC_DECAY, 4 * F_ONE, 3, 1'b1, 0, 1'b0);
		add_item(FUNC_LOAD_AVG, 0, 0, 1'b0, 0, 1'b0);
		add_item(FUNC_PRIORITY, -F_ONE, -20, 1'b0, 0, 1'b0);
		// Random part, in stretches that push the load average up, let it fall or mix.
		n_rand = 0;
		while (n_rand < 380) begin
			trend = load_trend_e'($urandom_range(0, 2));
			seg_len = (trend == TREND_UP) ? $urandom_range(40, 80) : $urandom_range(10, 60);
			repeat (seg_len) begin
				if (n_rand < 380) begin
					// The first random transaction, and at random one in fifty others, waits for the unit to drain completely.
					add_random_item(trend, n_rand == 0 || $urandom_range(0, 49) == 0);
					n_rand++;
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (req_queue.size() != 0 || in_valid);
		while (due_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
